// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// No dependencies; expects a clock aclk and an active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/oahi_pkg.sv
// Shared types, widths and hash helpers for the open-address hash insert block.
// No dependencies.
`default_nettype none

package oahi_pkg;

    localparam int ID_W     = 24;
    localparam int REC_W    = 32;
    localparam int SIZE_W   = 9;
    localparam int SLOT_W   = 8;
    localparam int DVD_W    = 21;
    localparam int NBITS_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 1'd1;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 9'd101;
    localparam logic [SIZE_W-1:0] ENTRY_MAX        = 9'd511;
    localparam logic [3:0]        PROBE_STEP_B     = 4'd7;
    localparam logic [7:0]        RECIP10          = 8'd205;
    localparam int                RECIP10_SH       = 11;

    typedef struct packed {
        logic [ID_W-1:0]  id_bcd;
        logic [REC_W-1:0] record_ref;
    } in_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] collisions;
        logic              status;
        logic [SIZE_W-1:0] entries;
    } out_beat_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [NBITS_W-1:0] nbits;
        logic [SIZE_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } mod_rsp_t;

    // ((10*d0 + d1) << 2) / 10; the shifted value stays below 1000, so no mod 1000.
    function automatic logic [6:0] hash_a_prefix(input logic [ID_W-1:0] id);
        logic [7:0]  pair;
        logic [9:0]  rot;
        logic [17:0] prod;
        pair = {1'b0, id[23:20], 3'b000} + {3'b000, id[23:20], 1'b0} + {4'd0, id[19:16]};
        rot  = {pair, 2'b00};
        prod = {8'd0, rot} * {10'd0, RECIP10};
        hash_a_prefix = prod[RECIP10_SH +: 7];
    endfunction

    function automatic logic [9:0] hash_b_sum(input logic [ID_W-1:0] id);
        logic [8:0] f1;
        logic [8:0] f2;
        f1 = {id[23:20], 5'd0} | {3'd0, id[15:12], 2'd0} | {5'd0, id[3:0]};
        f2 = {id[19:16], 5'd0} | {3'd0, id[11:8], 2'd0}  | {5'd0, id[7:4]};
        hash_b_sum = {1'b0, f1} + {1'b0, f2};
    endfunction

endpackage

`default_nettype wire

// File: rtl/open_address_hash_insert.sv
// Open-address hash insert: top level, sequencer, occupancy and key/record stores.
// Depends on oahi_pkg, oahi_mod_unit and assert_macros.svh.
//
//   channel | ports                      | moves
//   --------+----------------------------+---------------------------------
//   input   | s_valid s_ready s_data     | id_bcd, record_ref
//   result  | m_valid m_ready m_data     | slot, collisions, status, entries
//   config  | cfg_we cfg_index cfg_wdata | table_size, hash_mode
//
// After reset the occupancy store is swept clear, slot by slot, with s_ready low.
// One beat at a time: the hash goes through the bit-serial remainder unit, then
// each probe takes a read state and a check state.
// A finished result sits in the output register; a new beat is taken meanwhile.
`default_nettype none

module open_address_hash_insert #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire oahi_pkg::in_beat_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output oahi_pkg::out_beat_t                    m_data,
    input  wire logic                              cfg_we,
    input  wire logic [oahi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [oahi_pkg::SIZE_W-1:0]       cfg_wdata
);
    import oahi_pkg::*;

    `include "assert_macros.svh"

    localparam int ADDR_W   = $clog2(MAX_SLOTS);
    localparam int SIZE_CAP = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
    localparam int DEC_DIGITS = 6;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_DEC      = 7'b0000100,
        ST_MOD      = 7'b0001000,
        ST_PROBE_RD = 7'b0010000,
        ST_PROBE_CK = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        OP_STEP_A = 3'd0,
        OP_HA1    = 3'd1,
        OP_HA2    = 3'd2,
        OP_HB1    = 3'd3,
        OP_HB2    = 3'd4,
        OP_STEP_B = 3'd5
    } mod_op_t;

    state_t            state_reg, state_next;
    mod_op_t           op_reg, op_next;
    logic              start_reg, start_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [REC_W-1:0]  rec_reg, rec_next;
    logic [ID_W-1:0]   dig_sh_reg, dig_sh_next;
    logic [2:0]        dig_cnt_reg, dig_cnt_next;
    logic [DVD_W-1:0]  dec_reg, dec_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [SIZE_W-1:0] step_reg, step_next;
    logic [SIZE_W-1:0] coll_reg, coll_next;
    logic [SIZE_W-1:0] entry_reg, entry_next;
    out_beat_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;
    logic [SIZE_W-1:0] cfg_size_reg;
    logic              cfg_mode_reg;

    logic              occ_mem [MAX_SLOTS];
    logic [ID_W+REC_W-1:0] kv_mem [MAX_SLOTS];
    logic              occ_q;
    logic              occ_we;
    logic [ADDR_W-1:0] occ_waddr;
    logic              occ_wdata;
    logic              kv_we;

    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W:0]   probe_sum;
    logic [SIZE_W-1:0] probe_pos;
    logic [SIZE_W-1:0] entry_inc;
    logic              out_free;

    oahi_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mod_req (mod_req),
        .mod_rsp (mod_rsp)
    );

    always_comb begin
        if (cfg_size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (cfg_size_reg > SIZE_W'(SIZE_CAP)) begin
            size_eff = SIZE_W'(SIZE_CAP);
        end else begin
            size_eff = cfg_size_reg;
        end
    end

    assign probe_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    assign probe_pos = (probe_sum >= {1'b0, size_reg})
                     ? SIZE_W'(probe_sum - {1'b0, size_reg}) : probe_sum[SIZE_W-1:0];
    assign entry_inc = (entry_reg == ENTRY_MAX) ? entry_reg : entry_reg + SIZE_W'(1);
    assign out_free  = !m_valid_reg || m_ready;

    // Operand select for the remainder unit
    always_comb begin
        mod_req.start   = start_reg;
        mod_req.divisor = size_reg;
        mod_req.dividend = '0;
        mod_req.nbits    = NBITS_W'(DVD_W);
        case (op_reg)
            OP_STEP_A: begin
                mod_req.dividend = dec_reg;
                mod_req.nbits    = NBITS_W'(DVD_W);
            end
            OP_HA1: begin
                mod_req.dividend = DVD_W'(hash_a_prefix(id_reg));
                mod_req.nbits    = NBITS_W'(7);
            end
            OP_HA2: begin
                mod_req.dividend = DVD_W'({1'b0, pos_reg} + {6'd0, id_reg[23:20]});
                mod_req.nbits    = NBITS_W'(10);
            end
            OP_HB1: begin
                mod_req.dividend = DVD_W'(hash_b_sum(id_reg));
                mod_req.nbits    = NBITS_W'(10);
            end
            OP_HB2: begin
                mod_req.dividend = DVD_W'({1'b0, pos_reg} + {6'd0, PROBE_STEP_B});
                mod_req.nbits    = NBITS_W'(10);
            end
            OP_STEP_B: begin
                mod_req.dividend = DVD_W'(PROBE_STEP_B);
                mod_req.nbits    = NBITS_W'(3);
            end
            default: begin
                mod_req.dividend = '0;
                mod_req.nbits    = NBITS_W'(1);
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        start_next   = 1'b0;
        clr_next     = clr_reg;
        id_next      = id_reg;
        rec_next     = rec_reg;
        dig_sh_next  = dig_sh_reg;
        dig_cnt_next = dig_cnt_reg;
        dec_next     = dec_reg;
        size_next    = size_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        coll_next    = coll_reg;
        entry_next   = entry_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        occ_we       = 1'b0;
        occ_waddr    = ADDR_W'(pos_reg);
        occ_wdata    = 1'b1;
        kv_we        = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = clr_reg;
                occ_wdata = 1'b0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MAX_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    id_next      = s_data.id_bcd;
                    rec_next     = s_data.record_ref;
                    dig_sh_next  = s_data.id_bcd;
                    dig_cnt_next = '0;
                    dec_next     = '0;
                    size_next    = size_eff;
                    coll_next    = '0;
                    if (cfg_mode_reg) begin
                        op_next    = OP_HB1;
                        start_next = 1'b1;
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC: begin
                // v = 10*v + digit, most significant digit first
                dec_next = DVD_W'({dec_reg, 3'b000}) + DVD_W'({dec_reg, 1'b0})
                         + DVD_W'(dig_sh_reg[ID_W-1 -: 4]);
                dig_sh_next  = {dig_sh_reg[ID_W-5:0], 4'h0};
                dig_cnt_next = dig_cnt_reg + 3'd1;
                if (dig_cnt_reg == 3'(DEC_DIGITS - 1)) begin
                    op_next    = OP_STEP_A;
                    start_next = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_rsp.done) begin
                    case (op_reg)
                        OP_STEP_A: begin
                            step_next  = mod_rsp.rem;
                            op_next    = OP_HA1;
                            start_next = 1'b1;
                        end
                        OP_HA1: begin
                            pos_next   = mod_rsp.rem;
                            op_next    = OP_HA2;
                            start_next = 1'b1;
                        end
                        OP_HA2: begin
                            pos_next   = mod_rsp.rem;
                            state_next = ST_PROBE_RD;
                        end
                        OP_HB1: begin
                            pos_next   = mod_rsp.rem;
                            op_next    = OP_HB2;
                            start_next = 1'b1;
                        end
                        OP_HB2: begin
                            pos_next   = mod_rsp.rem;
                            op_next    = OP_STEP_B;
                            start_next = 1'b1;
                        end
                        OP_STEP_B: begin
                            step_next  = mod_rsp.rem;
                            state_next = ST_PROBE_RD;
                        end
                        default: begin
                            state_next = ST_PROBE_RD;
                        end
                    endcase
                end
            end
            ST_PROBE_RD: begin
                if (coll_reg == size_reg) begin
                    res_next.slot       = '0;
                    res_next.collisions = coll_reg;
                    res_next.status     = 1'b1;
                    res_next.entries    = entry_reg;
                    state_next          = ST_DONE;
                end else begin
                    state_next = ST_PROBE_CK;
                end
            end
            ST_PROBE_CK: begin
                if (!occ_q) begin
                    occ_we              = 1'b1;
                    kv_we               = 1'b1;
                    entry_next          = entry_inc;
                    res_next.slot       = pos_reg[SLOT_W-1:0];
                    res_next.collisions = coll_reg;
                    res_next.status     = 1'b0;
                    res_next.entries    = entry_inc;
                    state_next          = ST_DONE;
                end else begin
                    coll_next  = coll_reg + SIZE_W'(1);
                    pos_next   = probe_pos;
                    state_next = ST_PROBE_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            op_reg       <= OP_STEP_A;
            start_reg    <= 1'b0;
            clr_reg      <= '0;
            entry_reg    <= '0;
            m_valid_reg  <= 1'b0;
            cfg_size_reg <= TABLE_SIZE_RESET;
            cfg_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            start_reg   <= start_next;
            clr_reg     <= clr_next;
            entry_reg   <= entry_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TABLE_SIZE: cfg_size_reg <= cfg_wdata;
                    CFG_HASH_MODE:  cfg_mode_reg <= cfg_wdata[0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg      <= id_next;
        rec_reg     <= rec_next;
        dig_sh_reg  <= dig_sh_next;
        dig_cnt_reg <= dig_cnt_next;
        dec_reg     <= dec_next;
        size_reg    <= size_next;
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        coll_reg    <= coll_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        occ_q <= occ_mem[ADDR_W'(pos_reg)];
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            kv_mem[ADDR_W'(pos_reg)] <= {id_reg, rec_reg};
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPL(a_coll_bound, (state_reg == ST_PROBE_RD || state_reg == ST_PROBE_CK), coll_reg <= size_reg, "collision count above table size")
    `ASSERT_IMPL(a_pos_bound, (state_reg == ST_PROBE_RD || state_reg == ST_PROBE_CK), pos_reg < size_reg, "probe position outside table")
    `ASSERT_IMPL(a_mod_done, mod_rsp.done, state_reg == ST_MOD, "remainder done outside mod state")
    `ASSERT_NEXT(a_done_out, (state_reg == ST_DONE && out_free), m_valid && m_data == $past(res_reg), "result not moved to output")

endmodule

`default_nettype wire

// File: rtl/oahi_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on oahi_pkg.
`default_nettype none

module oahi_mod_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire oahi_pkg::mod_req_t mod_req,
    output oahi_pkg::mod_rsp_t      mod_rsp
);
    import oahi_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [NBITS_W-1:0] cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [SIZE_W-1:0]  dvs_reg;
    logic [SIZE_W-1:0]  rem_reg;

    logic [NBITS_W-1:0] bit_idx;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W-1:0]  rem_next;

    assign bit_idx = cnt_reg - NBITS_W'(1);
    assign trial   = {rem_reg, dvd_reg[bit_idx]};

    always_comb begin
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = SIZE_W'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (mod_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mod_req.nbits;
                dvd_reg  <= mod_req.dividend;
                dvs_reg  <= mod_req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                cnt_reg <= bit_idx;
                if (cnt_reg == NBITS_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign mod_rsp.done = done_reg;
    assign mod_rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for open_address_hash_insert: directed and random inserts checked beat by beat
// against a built-in model of the probe table. Depends on oahi_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb;
    import oahi_pkg::*;

    localparam int NUM_SLOTS = 256;
    localparam int RANDOM_ITEMS = 1620;
    localparam int DRAIN_CYCLES = 600;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    // model of the table
    logic [SIZE_W-1:0] cfg_size = TABLE_SIZE_RESET;
    logic cfg_mode = 1'b0;
    bit [NUM_SLOTS-1:0] occ_map = '0;
    int unsigned stored_count = 0;

    out_beat_t pending_results[$];
    out_beat_t head_result;
    int mismatches = 0;
    int sent_count = 0;
    int hold_left = 0;
    logic hold_start = 1'b0;
    bit quiet = 1'b0;

    open_address_hash_insert #(.MAX_SLOTS(NUM_SLOTS)) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic out_beat_t predict_insert(input logic [ID_W-1:0] id);
        int unsigned s, pos, step, coll, v, rot, f1, f2;
        int unsigned d [6];
        out_beat_t o;
        s = {23'd0, cfg_size};
        if (s == 0) s = 1;
        if (s > NUM_SLOTS) s = NUM_SLOTS;
        v = 0;
        for (int k = 0; k < 6; k++) begin
            d[k] = {28'd0, id[20 - 4 * k +: 4]};
            v = v * 10 + d[k];
        end
        if (cfg_mode == 1'b0) begin
            rot = (d[0] * 10 + d[1]) << 2;
            pos = ((((rot % 1000) / 10) % s) + d[0]) % s;
            step = v % s;
        end else begin
            f1 = (d[0] << 5) | (d[2] << 2) | d[5];
            f2 = (d[1] << 5) | (d[3] << 2) | d[4];
            pos = (((f1 + f2) % s) + 7) % s;
            step = 7 % s;
        end
        coll = 0;
        while (pos < NUM_SLOTS && occ_map[pos] && coll < s) begin
            coll++;
            pos = (pos + step) % s;
        end
        if (coll >= s || pos >= NUM_SLOTS) begin
            o.slot = '0;
            o.status = 1'b1;
        end else begin
            occ_map[pos] = 1'b1;
            if (stored_count < ENTRY_MAX) stored_count++;
            o.slot = pos[SLOT_W-1:0];
            o.status = 1'b0;
        end
        o.collisions = coll[SIZE_W-1:0];
        o.entries = stored_count[SIZE_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (hold_start) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // result side: check each beat, then drive ready for the next cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat, slot", m_data.slot, 0);
                end else begin
                    head_result = pending_results.pop_front();
                    if (m_data.slot !== head_result.slot)
                        report_mismatch("slot", m_data.slot, head_result.slot);
                    if (m_data.collisions !== head_result.collisions)
                        report_mismatch("collisions", m_data.collisions, head_result.collisions);
                    if (m_data.status !== head_result.status)
                        report_mismatch("status", m_data.status, head_result.status);
                    if (m_data.entries !== head_result.entries)
                        report_mismatch("entries", m_data.entries, head_result.entries);
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    task automatic send_insert(input logic [ID_W-1:0] id, input logic [REC_W-1:0] rec);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {id, rec};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_insert(id));
        sent_count++;
    endtask

    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TABLE_SIZE) cfg_size = value;
        else cfg_mode = value[0];
    endtask

    function automatic logic [ID_W-1:0] random_bcd();
        logic [ID_W-1:0] id;
        for (int k = 0; k < 6; k++) id[4 * k +: 4] = 4'($urandom_range(0, 9));
        return id;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        logic [ID_W-1:0] id;
        int pick;
        pick = $urandom_range(0, 99);
        id = random_bcd();
        if (pick >= 90) id[4 * $urandom_range(0, 5) +: 4] = 4'($urandom_range(10, 15));
        else if (pick >= 80) id = ID_W'($urandom());
        return id;
    endfunction

    task automatic test_reset_defaults();
        send_insert(24'h000000, 32'h0000_0000);
        send_insert(24'hFFFFFF, 32'hFFFF_FFFF);
        send_insert(24'h999999, $urandom());
        // zero ID gives probe step zero: same slot every probe
        send_insert(24'h000000, $urandom());
        send_insert(24'h000000, $urandom());
    endtask

    task automatic test_size_zero();
        write_reg(CFG_TABLE_SIZE, 9'd0);
        send_insert(24'h123456, $urandom());
        send_insert(24'h654321, $urandom());
    endtask

    task automatic test_size_above_max();
        write_reg(CFG_TABLE_SIZE, 9'd511);
        write_reg(CFG_HASH_MODE, 9'd1);
        send_insert(24'hFFFFFF, 32'hFFFF_FFFF);
        send_insert(24'h000000, 32'h0000_0000);
        send_insert(24'hABCDEF, $urandom());
    endtask

    task automatic test_short_probe_cycle();
        write_reg(CFG_TABLE_SIZE, 9'd7);
        repeat (3) send_insert(24'h314159, $urandom());
        write_reg(CFG_TABLE_SIZE, 9'd14);
        repeat (3) send_insert(24'h271828, $urandom());
    endtask

    task automatic test_full_table();
        write_reg(CFG_TABLE_SIZE, 9'd2);
        write_reg(CFG_HASH_MODE, 9'd0);
        repeat (4) send_insert(random_bcd(), $urandom());
    endtask

    task automatic test_shrunk_table();
        write_reg(CFG_TABLE_SIZE, 9'd40);
        write_reg(CFG_HASH_MODE, 9'd1);
        repeat (3) send_insert(random_bcd(), $urandom());
        write_reg(CFG_TABLE_SIZE, 9'd3);
        repeat (2) send_insert(random_bcd(), $urandom());
    endtask

    task automatic test_backpressure();
        write_reg(CFG_TABLE_SIZE, 9'd64);
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        repeat (12) send_insert(random_id(), $urandom());
    endtask

    task automatic test_random();
        int pick, len, lo, hi, base;
        logic [SIZE_W-1:0] size;
        base = sent_count;
        while (sent_count - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            lo = 1 + ((sent_count - base) * 255) / RANDOM_ITEMS;
            hi = (lo + 24 > NUM_SLOTS) ? NUM_SLOTS : lo + 24;
            if (pick < 5) size = 9'd0;
            else if (pick < 10) size = 9'd256;
            else if (pick < 14) size = 9'($urandom_range(257, 511));
            else if (pick < 20) size = 9'($urandom_range(1, 8));
            else if (pick < 25) size = 9'd1;
            else size = 9'($urandom_range(lo, hi));
            write_reg(CFG_TABLE_SIZE, size);
            write_reg(CFG_HASH_MODE, 9'($urandom_range(0, 1)));
            len = $urandom_range(20, 80);
            repeat (len) begin
                quiet = (sent_count - base >= 700) && (sent_count - base < 1000);
                send_insert(random_id(), $urandom());
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_size_zero();
        test_size_above_max();
        test_short_probe_cycle();
        test_full_table();
        test_shrunk_table();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/oahi_pkg.sv
rtl/oahi_mod_unit.sv
rtl/open_address_hash_insert.sv
sim/tb.sv
